[src/mbc1_pkg.sv]
// ----------------------------------------------------------------------------
// mbc1_pkg
// Shared types, constants and helper functions of the bank controller.
// ----------------------------------------------------------------------------
package mbc1_pkg;

    localparam int RAM_BANKS      = 4;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_BANK_W     = $clog2(RAM_BANKS);
    localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
    localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_ADDR_W     = $clog2(RAM_DEPTH);

    localparam int ROM_BANK_W = 7;
    localparam int ROM_OFS_W  = 14;
    localparam int ROM_ADDR_W = ROM_BANK_W + ROM_OFS_W;

    localparam int CFG_W = 3;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2
    } target_t;

    // bus_address[15:13]
    typedef enum logic [2:0] {
        REGION_RAM_EN    = 3'd0,
        REGION_LOW_BANK  = 3'd1,
        REGION_HIGH_BANK = 3'd2,
        REGION_MODE      = 3'd3,
        REGION_CART_RAM  = 3'd5
    } region_t;

    typedef enum logic {
        CFG_ROM_SIZE  = 1'b0,
        CFG_RAM_BANKS = 1'b1
    } cfg_index_t;

    // bank count minus one, code 7 gives 255
    function automatic logic [7:0] rom_bank_mask(input logic [2:0] code);
        logic [8:0] m;
        begin
            m = (9'd2 << code) - 9'd1;
            return m[7:0];
        end
    endfunction

    // effective ram bank count, saturated at RAM_BANKS
    function automatic logic [2:0] ram_banks_present(input logic [2:0] cnt);
        begin
            if (cnt > 3'(RAM_BANKS))
                return 3'(RAM_BANKS);
            else
                return cnt;
        end
    endfunction

    // high bank register modulo a bank count of 1 to 4
    function automatic logic [RAM_BANK_W-1:0] ram_bank_mod(input logic [1:0] bank,
                                                          input logic [2:0] n);
        logic [RAM_BANK_W-1:0] r;
        begin
            case (n)
                3'd1:    r = '0;
                3'd2:    r = RAM_BANK_W'({1'b0, bank[0]});
                3'd3:    r = (bank == 2'd3) ? '0 : RAM_BANK_W'(bank);
                default: r = RAM_BANK_W'(bank);
            endcase
            return r;
        end
    endfunction

endpackage

[src/mbc1_ram.sv]
// ----------------------------------------------------------------------------
// mbc1_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mbc1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/mbc1_bank_controller.sv]
// ----------------------------------------------------------------------------
// mbc1_bank_controller
// Cartridge bank controller: decodes bus requests, keeps the bank registers
// and the cartridge RAM, and returns ROM addresses or RAM data.
// ----------------------------------------------------------------------------
// path: a request accepted into the input register reaches the result
//   register together with the registered RAM read port
// throughput: one request per cycle while out_stall is low and no clearing pass runs
// reset: bank registers return to their defaults, then a clearing pass writes
//   zero to all 32768 RAM bytes, one per cycle; in_stall is high until the pass
//   ends, configuration writes are taken throughout
module mbc1_bank_controller import mbc1_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [15:0]           bus_address,
    input  logic [7:0]            write_data,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            target,
    output logic [ROM_ADDR_W-1:0] rom_address,
    output logic [7:0]            read_data
);

    // configuration and bank state
    logic [2:0]            rom_size_reg;
    logic [2:0]            ram_count_reg;
    logic                  ram_en_reg;
    logic [4:0]            low_bank_reg;
    logic [1:0]            high_bank_reg;
    logic                  bank_mode_reg;

    // clearing pass
    logic                  clr_busy_reg;
    logic [RAM_ADDR_W-1:0] clr_addr_reg;

    // input stage
    logic                  s1_valid_reg;
    logic                  s1_write_reg;
    logic [15:0]           s1_addr_reg;
    logic [7:0]            s1_data_reg;

    // result stage
    logic                  out_valid_reg;
    target_t               out_target_reg;
    logic [ROM_ADDR_W-1:0] out_rom_addr_reg;

    logic                  in_accept;
    logic                  adv;
    logic                  fire;
    region_t               region;
    logic [7:0]            bank_mask;
    logic [7:0]            bank_sum;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [ROM_BANK_W-1:0] zero_bank;
    logic [2:0]            ram_n;
    logic                  ram_ok;
    logic                  ram_hit;
    logic [RAM_ADDR_W-1:0] ram_addr;
    logic                  ram_we;
    logic                  ram_re;
    logic [RAM_ADDR_W-1:0] ram_port_addr;
    logic [7:0]            ram_wdata;
    logic [7:0]            ram_q;
    target_t               target_next;
    logic [ROM_ADDR_W-1:0] rom_addr_next;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = clr_busy_reg || (s1_valid_reg && !adv);
    assign in_accept = in_valid && !in_stall;
    assign fire      = s1_valid_reg && adv;

    // bank arithmetic
    assign region    = region_t'(s1_addr_reg[15:13]);
    assign bank_mask = rom_bank_mask(rom_size_reg);
    assign bank_sum  = {1'b0, high_bank_reg, low_bank_reg} & bank_mask;
    assign rom_bank  = (bank_sum[ROM_BANK_W-1:0] == '0) ? ROM_BANK_W'(1)
                                                        : bank_sum[ROM_BANK_W-1:0];
    assign zero_bank = bank_mode_reg ? ({high_bank_reg, 5'd0} & bank_mask[ROM_BANK_W-1:0])
                                     : '0;

    assign ram_n    = ram_banks_present(ram_count_reg);
    assign ram_ok   = ram_en_reg && (ram_n != 3'd0);
    assign ram_hit  = (region == REGION_CART_RAM) && ram_ok;
    assign ram_addr = {ram_bank_mod(bank_mode_reg ? high_bank_reg : 2'd0, ram_n),
                       s1_addr_reg[RAM_OFS_W-1:0]};

    assign ram_we        = clr_busy_reg || (fire && s1_write_reg && ram_hit);
    assign ram_re        = fire && !s1_write_reg && ram_hit;
    assign ram_port_addr = clr_busy_reg ? clr_addr_reg : ram_addr;
    assign ram_wdata     = clr_busy_reg ? 8'd0 : s1_data_reg;

    mbc1_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_port_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    // result decode for reads
    always_comb
    begin
        target_next   = TGT_NONE;
        rom_addr_next = '0;
        if (!s1_write_reg)
        begin
            if (!s1_addr_reg[15])
            begin
                target_next = TGT_ROM;
                if (!s1_addr_reg[14])
                    rom_addr_next = {zero_bank, s1_addr_reg[ROM_OFS_W-1:0]};
                else
                    rom_addr_next = {rom_bank, s1_addr_reg[ROM_OFS_W-1:0]};
            end
            else if (ram_hit)
            begin
                target_next = TGT_RAM;
            end
        end
    end

    // configuration and bank registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_reg  <= 3'd6;
            ram_count_reg <= 3'd4;
            ram_en_reg    <= 1'b0;
            low_bank_reg  <= '0;
            high_bank_reg <= '0;
            bank_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_ROM_SIZE:  rom_size_reg  <= cfg_data;
                    CFG_RAM_BANKS: ram_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (fire && s1_write_reg)
            begin
                case (region)
                    REGION_RAM_EN:    ram_en_reg    <= (s1_data_reg[3:0] == RAM_EN_KEY);
                    REGION_LOW_BANK:  low_bank_reg  <= s1_data_reg[4:0];
                    REGION_HIGH_BANK: high_bank_reg <= s1_data_reg[1:0];
                    REGION_MODE:      bank_mode_reg <= s1_data_reg[0];
                    default: ;
                endcase
            end
        end
    end

    // ram clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + RAM_ADDR_W'(1);
            if (clr_addr_reg == '1)
                clr_busy_reg <= 1'b0;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_write_reg <= mode;
            s1_addr_reg  <= bus_address;
            s1_data_reg  <= write_data;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_target_reg   <= target_next;
            out_rom_addr_reg <= rom_addr_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target      = out_target_reg;
    assign rom_address = out_rom_addr_reg;
    assign read_data   = (out_target_reg == TGT_RAM) ? ram_q : OPEN_BUS;

`ifndef SYNTH
    a_ram_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("ram written and read in the same cycle");

    a_ram_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (out_valid_reg && out_target_reg == TGT_RAM))
        else $error("ram read not followed by a ram result");

    a_ram_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && out_target_reg == TGT_RAM) |=> $stable(ram_q))
        else $error("ram read data changed under a stalled result");

    a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rom_bank != '0)
        else $error("switchable rom bank is zero");
`endif

endmodule

[dv/tb_mbc1_bank_controller.sv]
// ----------------------------------------------------------------------------
// tb_mbc1_bank_controller
// Self-checking bench for the cartridge bank controller. Bus requests go in
// with random gaps and results come out under random stalls. A bank model
// kept in the bench predicts each result, and every result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mbc1_bank_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import mbc1_pkg::*;

    typedef enum logic {
        ACC_READ  = 1'b0,
        ACC_WRITE = 1'b1
    } access_t;

    typedef struct {
        target_t                target;
        logic [ROM_ADDR_W-1:0]  rom_address;
        logic [7:0]             read_data;
    } bus_result_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic                  cfg_index   = 1'b0;
    logic [CFG_W-1:0]      cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  mode        = 1'b0;
    logic [15:0]           bus_address = '0;
    logic [7:0]            write_data  = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [1:0]            target;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [7:0]            read_data;

    // bank model state
    logic [2:0] rom_code_m    = 3'd6;
    logic [2:0] ram_count_m   = 3'd4;
    logic       ram_en_m      = 1'b0;
    logic [4:0] low_bank_m    = '0;
    logic [1:0] high_bank_m   = '0;
    logic       bank_mode_m   = 1'b0;
    logic [6:0] rom_bank_m    = 7'd1;
    logic [7:0] cart_ram_m [RAM_DEPTH];

    bus_result_t pending_results[$];
    int          mismatches = 0;
    bit          no_idle    = 1'b0;
    int          stall_left = 0;

    mbc1_bank_controller i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .bus_address (bus_address),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .target      (target),
        .rom_address (rom_address),
        .read_data   (read_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] rom_window_mask();
        logic [8:0] span;
        span = 9'(2 << rom_code_m);
        return 8'(span - 9'd1);
    endfunction

    function automatic void update_rom_bank();
        logic [7:0] b;
        b = (8'(low_bank_m) + (8'(high_bank_m) << 5)) & rom_window_mask();
        if (b == 8'd0)
            b = 8'd1;
        rom_bank_m = b[6:0];
    endfunction

    function automatic int ram_banks_m();
        return (ram_count_m > 3'(RAM_BANKS)) ? RAM_BANKS : int'(ram_count_m);
    endfunction

    function automatic int ram_index(logic [15:0] addr);
        int n;
        int bank;
        n = ram_banks_m();
        if (n == 0)
            return 0;
        bank = bank_mode_m ? int'(high_bank_m) : 0;
        bank = bank % n;
        return bank * RAM_BANK_BYTES + int'(addr[12:0]);
    endfunction

    // applies one request to the bank model and queues its result
    function automatic void predict_request(access_t acc, logic [15:0] addr,
                                            logic [7:0] data);
        bus_result_t r;
        bit          ram_ok;
        bit          in_ram_area;
        int          bank;
        r.target      = TGT_NONE;
        r.rom_address = '0;
        r.read_data   = OPEN_BUS;
        ram_ok        = ram_en_m && (ram_banks_m() != 0);
        in_ram_area   = (addr >= 16'hA000) && (addr < 16'hC000);
        if (acc == ACC_WRITE)
        begin
            if (addr < 16'h2000)
                ram_en_m = (data[3:0] == RAM_EN_KEY);
            else if (addr < 16'h4000)
            begin
                low_bank_m = data[4:0];
                update_rom_bank();
            end
            else if (addr < 16'h6000)
            begin
                high_bank_m = data[1:0];
                update_rom_bank();
            end
            else if (addr < 16'h8000)
            begin
                bank_mode_m = data[0];
                update_rom_bank();
            end
            else if (in_ram_area && ram_ok)
                cart_ram_m[ram_index(addr)] = data;
        end
        else
        begin
            if (addr < 16'h4000)
            begin
                // bank-0 window follows the high register only in mode 1
                bank = bank_mode_m ? int'((8'(high_bank_m) << 5) & rom_window_mask()) : 0;
                r.target      = TGT_ROM;
                r.rom_address = ROM_ADDR_W'(bank * (1 << ROM_OFS_W) + int'(addr));
            end
            else if (addr < 16'h8000)
            begin
                r.target      = TGT_ROM;
                r.rom_address = ROM_ADDR_W'(int'(rom_bank_m) * (1 << ROM_OFS_W)
                                            + int'(addr) - 16'h4000);
            end
            else if (in_ram_area && ram_ok)
            begin
                r.target    = TGT_RAM;
                r.read_data = cart_ram_m[ram_index(addr)];
            end
        end
        pending_results.push_back(r);
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // valid stays high on return so a back-to-back request needs no toggle
    task automatic send_request(access_t acc, logic [15:0] addr, logic [7:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= acc;
        bus_address <= addr;
        write_data  <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(acc, addr, data);
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(logic [2:0] rom_code, logic [2:0] ram_count);
        drain_requests();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROM_SIZE;
        cfg_data  <= rom_code;
        @(posedge clk);
        rom_code_m = rom_code;
        update_rom_bank();
        cfg_index <= CFG_RAM_BANKS;
        cfg_data  <= ram_count;
        @(posedge clk);
        ram_count_m = ram_count;
        update_rom_bank();
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // mostly four offsets at each end of a RAM bank, sometimes any offset, so writes get read back
    function automatic logic [15:0] ram_pool_address();
        logic [12:0] ofs;
        ofs = 13'($urandom_range(0, 3));
        if ($urandom_range(0, 1))
            ofs = ~ofs;
        if ($urandom_range(0, 9) == 0)
            ofs = 13'($urandom);
        return {REGION_CART_RAM, ofs};
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            stall_left = no_idle ? 0 : $urandom_range(0, 13);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        bus_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("unexpected result target=%0d rom_address=%h data=%h",
                                        target, rom_address, read_data));
            else
            begin
                exp_r = pending_results.pop_front();
                if (target !== exp_r.target)
                    flag_mismatch($sformatf("target exp %0d got %0d", exp_r.target, target));
                if (rom_address !== exp_r.rom_address)
                    flag_mismatch($sformatf("rom_address exp %h got %h",
                                            exp_r.rom_address, rom_address));
                if (read_data !== exp_r.read_data)
                    flag_mismatch($sformatf("read_data exp %h got %h",
                                            exp_r.read_data, read_data));
            end
        end
    end

    task automatic test_directed();
        no_idle = 1'b0;
        send_request(ACC_READ,  16'h0000, 8'h00);
        send_request(ACC_READ,  16'h3FFF, 8'hFF);
        send_request(ACC_READ,  16'h4000, 8'h00);
        send_request(ACC_READ,  16'h7FFF, 8'h00);
        send_request(ACC_READ,  16'h8000, 8'h00);
        // RAM still disabled
        send_request(ACC_READ,  16'hA000, 8'h00);
        send_request(ACC_READ,  16'hC000, 8'h00);
        send_request(ACC_READ,  16'hFFFF, 8'h00);
        send_request(ACC_WRITE, 16'h0000, 8'h0A);
        // cleared RAM reads zero
        send_request(ACC_READ,  16'hBFFF, 8'h00);
        send_request(ACC_WRITE, 16'hA000, 8'hFF);
        send_request(ACC_WRITE, 16'hBFFF, 8'h00);
        send_request(ACC_READ,  16'hA000, 8'h00);
        send_request(ACC_READ,  16'hBFFF, 8'h00);
        // a nibble other than the key disables
        send_request(ACC_WRITE, 16'h1FFF, 8'hF5);
        send_request(ACC_READ,  16'hA000, 8'h00);
        send_request(ACC_WRITE, 16'h1FFF, 8'hFA);
        // low bank zero maps to bank one
        send_request(ACC_WRITE, 16'h2000, 8'h00);
        send_request(ACC_READ,  16'h4000, 8'h00);
        send_request(ACC_WRITE, 16'h3FFF, 8'hFF);
        send_request(ACC_WRITE, 16'h5FFF, 8'hFF);
        send_request(ACC_READ,  16'h7FFF, 8'h00);
        send_request(ACC_WRITE, 16'h6000, 8'h01);
        send_request(ACC_READ,  16'h0000, 8'h00);
        send_request(ACC_READ,  16'hA000, 8'h00);
        send_request(ACC_WRITE, 16'h7FFF, 8'hFE);
        // writes outside the decoded ranges are dropped
        send_request(ACC_WRITE, 16'h8000, 8'h55);
        send_request(ACC_WRITE, 16'hC000, 8'hAA);
        send_request(ACC_WRITE, 16'hFFFF, 8'h12);
        send_request(ACC_READ,  16'hA000, 8'h00);
    endtask

    task automatic test_rom_banking();
        int pick;
        for (int code = 0; code < 8; code++)
        begin
            write_config(3'(code), 3'($urandom_range(0, 7)));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (60)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    send_request(ACC_WRITE, {REGION_LOW_BANK, 13'($urandom)}, 8'($urandom));
                else if (pick < 27)
                    send_request(ACC_WRITE, {REGION_HIGH_BANK, 13'($urandom)}, 8'($urandom));
                else if (pick < 37)
                    send_request(ACC_WRITE, {REGION_MODE, 13'($urandom)}, 8'($urandom));
                else
                    send_request(ACC_READ, {1'b0, 15'($urandom)}, 8'($urandom));
            end
        end
    endtask

    task automatic test_ram_banking();
        int         pick;
        logic [7:0] en_data;
        for (int count = 0; count < 8; count++)
        begin
            write_config(3'($urandom_range(0, 7)), 3'(count));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (80)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    en_data = ($urandom_range(0, 4) != 0) ? {4'($urandom), RAM_EN_KEY}
                                                          : 8'($urandom);
                    send_request(ACC_WRITE, {REGION_RAM_EN, 13'($urandom)}, en_data);
                end
                else if (pick < 20)
                    send_request(ACC_WRITE, {REGION_HIGH_BANK, 13'($urandom)}, 8'($urandom));
                else if (pick < 30)
                    send_request(ACC_WRITE, {REGION_MODE, 13'($urandom)}, 8'($urandom));
                else if (pick < 65)
                    send_request(ACC_WRITE, ram_pool_address(), 8'($urandom));
                else
                    send_request(ACC_READ, ram_pool_address(), 8'($urandom));
            end
        end
    endtask

    task automatic test_random_mix();
        int         pick;
        logic [7:0] ctl_data;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 0)
                write_config(3'd7, 3'd4);
            else if (phase == 1)
                write_config(3'd0, 3'd0);
            else
                write_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            no_idle = (phase == 2);
            repeat (220)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    send_request(access_t'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
                else if (pick < 30)
                begin
                    ctl_data = $urandom_range(0, 1) ? {4'($urandom), RAM_EN_KEY}
                                                    : 8'($urandom);
                    send_request(ACC_WRITE, 16'($urandom_range(0, 16'h7FFF)), ctl_data);
                end
                else if (pick < 60)
                    send_request(ACC_READ, {1'b0, 15'($urandom)}, 8'($urandom));
                else if (pick < 80)
                    send_request(ACC_WRITE, ram_pool_address(), 8'($urandom));
                else
                    send_request(ACC_READ, ram_pool_address(), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        foreach (cart_ram_m[i])
            cart_ram_m[i] = 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_rom_banking();
        test_ram_banking();
        test_random_mix();
        drain_requests();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // covers the RAM clearing pass after reset plus worst-case gaps and stalls
    initial
    begin
        #2_000_000;
        $display("timeout with %0d requests outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
